// ----- src/stbs_pkg.sv -----
package stbs_pkg;

    localparam int unsigned TableDepth = 256;
    localparam int unsigned KeyWidth   = 32;
    localparam int unsigned IdxWidth   = 8;
    localparam int unsigned ModeWidth  = 3;
    localparam int unsigned QueueDepth = 2;

    // item kinds
    localparam logic [2:0] MODE_WRITE    = 3'd0;
    localparam logic [2:0] MODE_EXACT    = 3'd1;
    localparam logic [2:0] MODE_FIRST_GE = 3'd2;
    localparam logic [2:0] MODE_FIRST_GT = 3'd3;
    localparam logic [2:0] MODE_LAST_LT  = 3'd4;
    localparam logic [2:0] MODE_LAST_LE  = 3'd5;

    // configuration register indexes
    localparam logic [0:0] REG_FIRST_INDEX = 1'd0;
    localparam logic [0:0] REG_LAST_INDEX  = 1'd1;

    // classified query handed from front to back
    typedef struct packed {
        logic [2:0]          mode;
        logic                empty;
        logic [IdxWidth:0]   lo;
        logic [IdxWidth:0]   hi_end;
        logic [KeyWidth-1:0] key;
    } query_t;

endpackage

// ----- src/sorted_table_bound_search.sv -----
// sorted table bound search
// s_axis beats carry a write or a query; writes (mode 0) store key at
// entry_index and give no result, modes 1..5 search [first_index,
// last_index] by bisection and give one m_axis beat; modes 6, 7 are dropped.
// cfg_we/cfg_index/cfg_data write first_index (0) and last_index (1).
// a front stage classifies beats and pushes queries into a two-entry queue;
// the back sequencer takes each query through the single table read port:
// one read and one compare per bisection step, in the READ and CMP states.
// an empty range skips the bisection. the sequencer works on one query at
// a time, and the queue takes up to two more queries meanwhile. a write is
// taken only once the queue and the sequencer are idle, and is stored as
// it is taken.
// result sits in an output register; a stalled receiver holds it and the
// sequencer waits, and once the queue fills s_axis_tready drops.
// reset clears the range to 0..255 and all control; table contents are
// undefined until written.
module sorted_table_bound_search #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TableDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mode[2:0], entry_index[10:3], key[42:11], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // found[0], position[8:1], entry_value[40:9], zero pad
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic             wr_en;
    logic [7:0]       wr_index;
    logic [31:0]      wr_key;
    logic             q_push, q_full, q_pop, q_valid;
    stbs_pkg::query_t q_in, q_out;
    logic [AW-1:0]    rd_addr;
    logic [31:0]      rd_data;
    logic             o_found;
    logic [7:0]       o_pos;
    logic [31:0]      o_val;
    logic             back_idle;

    stbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_mode(s_axis_tdata[2:0]), .in_index(s_axis_tdata[10:3]),
        .in_key(s_axis_tdata[42:11]),
        .wr_en(wr_en), .wr_index(wr_index), .wr_key(wr_key),
        .q_push(q_push), .q_data(q_in), .q_full(q_full),
        .wr_allow(back_idle && !q_valid)
    );

    stbs_queue #(.DEPTH(stbs_pkg::QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
    );

    stbs_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(wr_en), .waddr(AW'(wr_index)), .wdata(wr_key),
        .raddr(rd_addr), .rdata(rd_data)
    );

    stbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_out),
        .rd_addr(rd_addr), .rd_data(rd_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_found(o_found), .out_position(o_pos), .out_value(o_val),
        .idle(back_idle)
    );

    assign m_axis_tdata = {7'd0, o_val, o_pos, o_found};

endmodule

// ----- src/stbs_ram.sv -----
module stbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/stbs_front.sv -----
module stbs_front #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TableDepth
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [stbs_pkg::IdxWidth-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      in_mode,
    input  logic [stbs_pkg::IdxWidth-1:0]   in_index,
    input  logic [stbs_pkg::KeyWidth-1:0]   in_key,
    output logic                            wr_en,
    output logic [stbs_pkg::IdxWidth-1:0]   wr_index,
    output logic [stbs_pkg::KeyWidth-1:0]   wr_key,
    output logic                            q_push,
    output stbs_pkg::query_t                q_data,
    input  logic                            q_full,
    input  logic                            wr_allow
);

    localparam int unsigned IW = stbs_pkg::IdxWidth;
    localparam logic [IW:0] MaxPos = (IW+1)'(TABLE_DEPTH - 1);

    logic [IW-1:0] first_reg;
    logic [IW-1:0] last_reg;
    logic [IW:0]   hi_clip;
    logic          accept;
    logic          is_query;

    // range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            last_reg  <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stbs_pkg::REG_FIRST_INDEX: first_reg <= cfg_data;
                stbs_pkg::REG_LAST_INDEX:  last_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify beat; a write waits until no search is queued or running
    assign in_ready = !q_full && ((in_mode != stbs_pkg::MODE_WRITE) || wr_allow);
    assign accept   = in_valid && in_ready;
    assign is_query = (in_mode == stbs_pkg::MODE_EXACT)
                   || (in_mode == stbs_pkg::MODE_FIRST_GE)
                   || (in_mode == stbs_pkg::MODE_FIRST_GT)
                   || (in_mode == stbs_pkg::MODE_LAST_LT)
                   || (in_mode == stbs_pkg::MODE_LAST_LE);

    assign wr_en    = accept && (in_mode == stbs_pkg::MODE_WRITE)
                   && ({1'b0, in_index} <= MaxPos);
    assign wr_index = in_index;
    assign wr_key   = in_key;

    assign hi_clip = ({1'b0, last_reg} > MaxPos) ? MaxPos : {1'b0, last_reg};

    assign q_push        = accept && is_query;
    assign q_data.mode   = in_mode;
    assign q_data.empty  = {1'b0, first_reg} > hi_clip;
    assign q_data.lo     = {1'b0, first_reg};
    assign q_data.hi_end = hi_clip + 1'b1;
    assign q_data.key    = in_key;

endmodule

// ----- src/stbs_queue.sv -----
module stbs_queue #(
    parameter int unsigned DEPTH = stbs_pkg::QueueDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stbs_pkg::query_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output stbs_pkg::query_t  pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    stbs_pkg::query_t slot_reg [DEPTH];
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    rp_reg;
    logic [PW:0]      cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = slot_reg[rp_reg];

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop && not_empty)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && !full) - (PW+1)'(pop && not_empty);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(DEPTH)) else $error("queue count overflow");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full) else $error("full queue lost an entry");
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty && !push |=> !not_empty) else $error("queue gained an entry");
`endif

endmodule

// ----- src/stbs_back.sv -----
module stbs_back #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TableDepth
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  stbs_pkg::query_t                q_data,
    output logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
    input  logic [stbs_pkg::KeyWidth-1:0]   rd_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_found,
    output logic [stbs_pkg::IdxWidth-1:0]   out_position,
    output logic [stbs_pkg::KeyWidth-1:0]   out_value,
    output logic                            idle
);

    localparam int unsigned IW = stbs_pkg::IdxWidth;
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned KW = stbs_pkg::KeyWidth;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    stbs_pkg::query_t   q_reg;
    logic [IW:0]        lo_reg, lo_next;
    logic [IW:0]        hi_reg, hi_next;
    logic [IW:0]        mid;
    logic [IW:0]        pos_reg, pos_next;
    logic               found_reg, found_next;
    logic               ovalid_reg;
    logic               ofound_reg;
    logic [IW-1:0]      opos_reg;
    logic [KW-1:0]      oval_reg;
    logic               strict;
    logic               go_right;
    logic               out_free;
    logic [IW:0]        rd_pos;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign strict   = (q_reg.mode == stbs_pkg::MODE_EXACT)
                   || (q_reg.mode == stbs_pkg::MODE_FIRST_GE)
                   || (q_reg.mode == stbs_pkg::MODE_LAST_LT);
    assign go_right = strict ? ($signed(rd_data) < $signed(q_reg.key))
                             : !($signed(q_reg.key) < $signed(rd_data));
    assign out_free = !ovalid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign rd_pos   = (state_reg == ST_READ) ? mid : pos_reg;
    assign rd_addr  = rd_pos[AW-1:0];
    assign idle     = (state_reg == ST_IDLE);

    // bisection sequencer: one table read and compare per step
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    lo_next    = q_data.lo;
                    hi_next    = q_data.hi_end;
                    state_next = q_data.empty ? ST_DONE : ST_READ;
                    found_next = 1'b0;
                end
            end
            ST_READ:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    priority if (q_reg.mode == stbs_pkg::MODE_EXACT ||
                                 q_reg.mode == stbs_pkg::MODE_FIRST_GE ||
                                 q_reg.mode == stbs_pkg::MODE_FIRST_GT)
                    begin
                        found_next = lo_reg < q_reg.hi_end;
                        pos_next   = lo_reg;
                    end
                    else
                    begin
                        found_next = lo_reg > q_reg.lo;
                        pos_next   = lo_reg - 1'b1;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_READ;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            if (state_reg == ST_DONE && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        pos_reg <= pos_next;
        if (q_pop)
        begin
            q_reg <= q_data;
        end
        // exact mode also needs the value to match
        if (state_reg == ST_DONE && out_free)
        begin
            if (found_reg && (q_reg.mode != stbs_pkg::MODE_EXACT || rd_data == q_reg.key))
            begin
                ofound_reg <= 1'b1;
                opos_reg   <= pos_reg[IW-1:0];
                oval_reg   <= rd_data;
            end
            else
            begin
                ofound_reg <= 1'b0;
                opos_reg   <= '0;
                oval_reg   <= '0;
            end
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_found    = ofound_reg;
    assign out_position = opos_reg;
    assign out_value    = oval_reg;

`ifndef SYNTH
    a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (lo_reg < hi_reg)) else $error("bisect range empty");
    a_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (hi_reg - lo_reg) < $past(hi_reg - lo_reg))
        else $error("bisect range did not shrink");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_position))
        else $error("result dropped while stalled");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  entry_index;
        logic [31:0] key;
    } beat_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  position;
        logic [31:0] entry_value;
    } bound_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // mode[2:0], entry_index[10:3], key[42:11], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // found[0], position[8:1], entry_value[40:9], zero pad

    // stimulus and scoreboard state
    beat_t        pending_beats[$];
    bound_t       expected_bounds[$];
    logic [31:0]  table_copy[stbs_pkg::TableDepth];   // updated on accepted beats
    logic [31:0]  gen_table[stbs_pkg::TableDepth];    // what the generator has written
    logic [7:0]   range_lo;
    logic [7:0]   range_hi;
    logic         in_taken;
    logic         calm;
    int           mismatches;
    int           queries_seen;

    sorted_table_bound_search u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // first position whose entry fails entry < key (strict) or entry <= key
    function automatic int split_point(int lo, int hi_end, logic [31:0] key, bit strict);
        int mid;
        bit go_right;
        while (lo < hi_end)
        begin
            mid = lo + (hi_end - lo) / 2;
            if (strict)
                go_right = $signed(table_copy[mid]) < $signed(key);
            else
                go_right = $signed(table_copy[mid]) <= $signed(key);
            if (go_right)
                lo = mid + 1;
            else
                hi_end = mid;
        end
        return lo;
    endfunction

    function automatic bound_t find_bound(logic [2:0] mode, logic [31:0] key);
        bound_t r;
        int lo;
        int hi_end;
        int b;
        r = '0;
        lo = range_lo;
        hi_end = int'(range_hi) + 1;
        if (lo < hi_end)
        begin
            b = split_point(lo, hi_end, key,
                            mode == stbs_pkg::MODE_EXACT || mode == stbs_pkg::MODE_FIRST_GE
                            || mode == stbs_pkg::MODE_LAST_LT);
            case (mode)
                stbs_pkg::MODE_EXACT:
                    if (b < hi_end && table_copy[b] == key)
                    begin
                        r.found = 1'b1;
                        r.position = b[7:0];
                    end
                stbs_pkg::MODE_FIRST_GE, stbs_pkg::MODE_FIRST_GT:
                    if (b < hi_end)
                    begin
                        r.found = 1'b1;
                        r.position = b[7:0];
                    end
                default:
                    if (b > lo)
                    begin
                        r.found = 1'b1;
                        r.position = 8'(b - 1);
                    end
            endcase
            if (r.found)
                r.entry_value = table_copy[r.position];
        end
        return r;
    endfunction

    // input driver
    always @(negedge clk or negedge rst_n)
    begin
        beat_t nb;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(99) >= 7);
            if (!s_axis_tvalid || in_taken)
            begin
                if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 7))
                begin
                    nb = pending_beats.pop_front();
                    s_axis_tdata  <= {5'b0, nb.key, nb.entry_index, nb.mode};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // input monitor: update table copy and predict query results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[2:0] == stbs_pkg::MODE_WRITE)
                    table_copy[s_axis_tdata[10:3]] = s_axis_tdata[42:11];
                else if (s_axis_tdata[2:0] <= stbs_pkg::MODE_LAST_LE)
                    expected_bounds.push_back(find_bound(s_axis_tdata[2:0],
                                                         s_axis_tdata[42:11]));
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        bound_t got;
        bound_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[40:9]};
            queries_seen++;
            if (expected_bounds.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            end
            else
            begin
                want = expected_bounds.pop_front();
                if (got.found !== want.found)
                begin
                    mismatches++;
                    $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
                end
                if (got.position !== want.position)
                begin
                    mismatches++;
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, got.position);
                end
                if (got.entry_value !== want.entry_value)
                begin
                    mismatches++;
                    $display("%0t: entry_value expected %0d actual %0d",
                             $time, $signed(want.entry_value), $signed(got.entry_value));
                end
                if (m_axis_tdata[47:41] !== '0)
                begin
                    mismatches++;
                    $display("%0t: pad bits expected 0 actual %h", $time, m_axis_tdata[47:41]);
                end
            end
        end
    end

    task automatic push_beat(logic [2:0] mode, logic [7:0] idx, logic [31:0] key);
        beat_t b;
        b.mode = mode;
        b.entry_index = idx;
        b.key = key;
        if (mode == stbs_pkg::MODE_WRITE)
            gen_table[idx] = key;
        pending_beats.push_back(b);
    endtask

    // wait until every beat is in and every result is out, plus write latency
    task automatic wait_quiet();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_bounds.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == stbs_pkg::REG_FIRST_INDEX)
            range_lo = value;
        else
            range_hi = value;
    endtask

    function automatic logic [31:0] pick_key();
        logic [31:0] v;
        v = gen_table[$urandom_range(255)];
        case ($urandom_range(9))
            0, 1, 2: return v;
            3, 4:    return v + 32'd1;
            5, 6:    return v - 32'd1;
            7:       return $urandom();
            8:       return 32'h8000_0000;
            default: return 32'h7fff_ffff;
        endcase
    endfunction

    // write that mostly keeps the table in order
    task automatic random_write();
        int unsigned i;
        longint lo_v;
        longint hi_v;
        i = $urandom_range(255);
        if ($urandom_range(19) == 0)
            push_beat(stbs_pkg::MODE_WRITE, i[7:0], $urandom());
        else
        begin
            lo_v = (i == 0) ? -64'sd2147483648 : longint'($signed(gen_table[i - 1]));
            hi_v = (i == 255) ? 64'sd2147483647 : longint'($signed(gen_table[i + 1]));
            if (lo_v > hi_v)
                push_beat(stbs_pkg::MODE_WRITE, i[7:0], gen_table[i]);
            else
                push_beat(stbs_pkg::MODE_WRITE, i[7:0],
                          32'(lo_v + longint'({$urandom(), $urandom()} % (hi_v - lo_v + 1))));
        end
    endtask

    task automatic random_phase(int count);
        int n;
        logic [2:0] m;
        for (n = 0; n < count; n++)
        begin
            m = 3'($urandom_range(1, 5));
            case ($urandom_range(19))
                0, 1, 2, 3: random_write();
                4:          push_beat(3'($urandom_range(6, 7)), 8'($urandom()), $urandom());
                default:    push_beat(m, 8'($urandom()), pick_key());
            endcase
        end
    endtask

    // main sequence
    initial
    begin
        int i;
        int p;
        logic [2:0] m;
        mismatches   = 0;
        queries_seen = 0;
        calm         = 1'b0;
        range_lo     = 8'd0;
        range_hi     = 8'd255;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole table in order, pairs of duplicates, both extremes
        for (i = 0; i < 256; i++)
            push_beat(stbs_pkg::MODE_WRITE, i[7:0], 32'h8000_0000 + 32'((i / 2) * 33554432));
        push_beat(stbs_pkg::MODE_WRITE, 8'd255, 32'h7fff_ffff);
        wait_quiet();
        write_reg(stbs_pkg::REG_FIRST_INDEX, 8'd0);
        write_reg(stbs_pkg::REG_LAST_INDEX, 8'd255);

        // directed: every query mode at the key extremes and around duplicates
        for (m = stbs_pkg::MODE_EXACT; m <= stbs_pkg::MODE_LAST_LE; m++)
        begin
            push_beat(m, 8'hff, 32'h8000_0000);
            push_beat(m, 8'h00, 32'h7fff_ffff);
            push_beat(m, 8'h00, gen_table[100]);
            push_beat(m, 8'h00, gen_table[100] + 32'd1);
        end
        push_beat(3'd6, 8'hff, 32'hffff_ffff);
        push_beat(3'd7, 8'h00, 32'h0);
        random_phase(120);

        // range settings, extremes and an empty range among them
        for (p = 0; p < 6; p++)
        begin
            wait_quiet();
            case (p)
                0:
                begin
                    write_reg(stbs_pkg::REG_FIRST_INDEX, 8'd0);
                    write_reg(stbs_pkg::REG_LAST_INDEX, 8'd0);
                end
                1:
                begin
                    write_reg(stbs_pkg::REG_FIRST_INDEX, 8'd255);
                    write_reg(stbs_pkg::REG_LAST_INDEX, 8'd255);
                end
                2:
                begin
                    write_reg(stbs_pkg::REG_FIRST_INDEX, 8'd10);
                    write_reg(stbs_pkg::REG_LAST_INDEX, 8'd3);
                end
                3:
                begin
                    write_reg(stbs_pkg::REG_FIRST_INDEX, 8'($urandom()));
                    write_reg(stbs_pkg::REG_LAST_INDEX, 8'($urandom()));
                end
                4:
                begin
                    write_reg(stbs_pkg::REG_FIRST_INDEX, 8'd5);
                    write_reg(stbs_pkg::REG_LAST_INDEX, 8'd200);
                end
                default:
                begin
                    write_reg(stbs_pkg::REG_FIRST_INDEX, 8'd0);
                    write_reg(stbs_pkg::REG_LAST_INDEX, 8'd255);
                end
            endcase
            // one stretch runs with no idling on either side
            calm = (p == 4);
            random_phase((p == 5) ? 50 : 120);
        end
        calm = 1'b0;
        wait_quiet();

        if (expected_bounds.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_bounds.size());
        end
        $display("covered %0d query results over six range settings, with table writes",
                 queries_seen);
        $display("and ignored modes mixed in, under random idling on both sides");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
